/* rtl/core/stm3_pkg.sv */
// ----------------------------------------------------------------------------
// stm3_pkg
// Shared types and constants of the three-phase stepper move generator.
// ----------------------------------------------------------------------------
package stm3_pkg;

  // field and register widths
  localparam int TGT_W       = 16;  // target position, signed
  localparam int UPS_W       = 8;   // units_per_step
  localparam int BASE_W      = 16;  // base_half_period
  localparam int PPP_W       = 16;  // pulses per phase
  localparam int IDX_W       = 17;  // pulse index, reaches pulses per phase + 1
  localparam int ANUM_W      = 32;  // accelerate numerator
  localparam int PROD_W      = BASE_W + IDX_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  // shared divider
  localparam int DVD_W       = 32;
  localparam int DVS_W       = 19;
  localparam int DIV_CNT_W   = $clog2(DVD_W);

  // each phase runs 1 + |d| / 3 pulses; |d| / 3 is a reciprocal multiply,
  // exact for any 32-bit |d|
  localparam logic [DVD_W-1:0] THIRD_RECIP = 32'hAAAA_AAAB;
  localparam int               THIRD_SHIFT = 33;

  // configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] REG_UPS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'b1;
  localparam logic [UPS_W-1:0]     UPS_RESET  = 8'd1;
  localparam logic [BASE_W-1:0]    BASE_RESET = 16'd500;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ACCEL  = 4'b0010,
    PH_CRUISE = 4'b0100,
    PH_DECEL  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    DIV_TGT = 2'd0,  // |target| / units_per_step
    DIV_HP  = 2'd1   // accel numerator / (3 * index)
  } div_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     pos_update;
    logic     move_load;
    logic     tick_apply;
    logic     mul_load;
    logic     hp_load;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic action;
    logic hp_pend;
    logic phase_accel;
    logic div_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* rtl/core/stm3_div.sv */
// ----------------------------------------------------------------------------
// stm3_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stm3_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [stm3_pkg::DVD_W-1:0]     dividend,
  input  logic [stm3_pkg::DVS_W-1:0]     divisor,
  output logic                           done,
  output logic [stm3_pkg::DVD_W-1:0]     quo
);

  localparam int DVD_W = stm3_pkg::DVD_W;
  localparam int DVS_W = stm3_pkg::DVS_W;
  localparam int CNT_W = stm3_pkg::DIV_CNT_W;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;   // dividend shifts out, quotient shifts in
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_new;
  logic             q_bit;

  always_comb begin
    rem_sh  = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
    q_bit   = (rem_sh >= {1'b0, dvs_r});
    rem_new = q_bit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], q_bit};
      rem_r <= rem_new;
    end
  end

  assign done = done_r;
  assign quo  = dvd_r;

endmodule

/* rtl/core/stm3_ctrl.sv */
// ----------------------------------------------------------------------------
// stm3_ctrl
// Sequencer: walks one request through decode, divides and result hand-off.
// ----------------------------------------------------------------------------
module stm3_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  stm3_pkg::ctrl_stat_t   st,
  output stm3_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_DISP    = 8'b00000010,
    S_TGT_DIV = 8'b00000100,
    S_MAG     = 8'b00001000,
    S_HP_CHK  = 8'b00010000,
    S_HP_DIV  = 8'b00100000,
    S_HP_LOAD = 8'b01000000,
    S_OUT     = 8'b10000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        if (st.action) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = stm3_pkg::DIV_TGT;
          state_nxt     = S_TGT_DIV;
        end else begin
          cmd.tick_apply = 1'b1;
          state_nxt      = S_HP_CHK;
        end
      end
      S_TGT_DIV: begin
        if (st.div_done) begin
          cmd.pos_update = 1'b1;
          state_nxt      = S_MAG;
        end
      end
      S_MAG: begin
        cmd.move_load = 1'b1;
        state_nxt     = S_OUT;
      end
      S_HP_CHK: begin
        if (!st.hp_pend) begin
          state_nxt = S_OUT;
        end else if (st.phase_accel) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = stm3_pkg::DIV_HP;
          state_nxt     = S_HP_DIV;
        end else begin
          cmd.mul_load = 1'b1;
          state_nxt    = S_HP_LOAD;
        end
      end
      S_HP_DIV: begin
        if (st.div_done) begin
          cmd.hp_load = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_HP_LOAD: begin
        cmd.hp_load = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/stm3_dp.sv */
// ----------------------------------------------------------------------------
// stm3_dp
// Datapath: config registers, axis state, divider operands, half-period
// math and the result register.
// ----------------------------------------------------------------------------
module stm3_dp #(
  parameter int POSITION_BITS = 16,
  parameter int PERIOD_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  stm3_pkg::ctrl_cmd_t                  cmd,
  output stm3_pkg::ctrl_stat_t                 st,
  input  logic [stm3_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tuser,
  input  logic                                 cfg_we,
  input  logic [stm3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stm3_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [stm3_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int P      = POSITION_BITS;
  localparam int TGT_W  = stm3_pkg::TGT_W;
  localparam int UPS_W  = stm3_pkg::UPS_W;
  localparam int BASE_W = stm3_pkg::BASE_W;
  localparam int PPP_W  = stm3_pkg::PPP_W;
  localparam int IDX_W  = stm3_pkg::IDX_W;
  localparam int ANUM_W = stm3_pkg::ANUM_W;
  localparam int PROD_W = stm3_pkg::PROD_W;
  localparam int DVD_W  = stm3_pkg::DVD_W;
  localparam int DVS_W  = stm3_pkg::DVS_W;
  localparam int EXT_W  = (P > TGT_W + 1) ? P : TGT_W + 1;
  localparam int SAT_W  = (PERIOD_BITS > PROD_W) ? PERIOD_BITS : PROD_W;

  // configuration
  logic [UPS_W-1:0]  ups_r;
  logic [BASE_W-1:0] base_r;

  // latched request
  logic             act_r;
  logic [TGT_W-1:0] tgt_r;
  logic             sws_r;
  logic             swe_r;

  // axis state
  logic [P-1:0]           pos_r,   pos_nxt;
  stm3_pkg::phase_t       phase_r, phase_nxt;
  logic [IDX_W-1:0]       idx_r,   idx_nxt;
  logic [PPP_W-1:0]       ppp_r,   ppp_nxt;
  logic [ANUM_W-1:0]      anum_r,  anum_nxt;
  logic [PERIOD_BITS-1:0] count_r, count_nxt;
  logic                   level_r, level_nxt;
  logic                   dir_r,   dir_nxt;
  logic                   abort_r, abort_nxt;
  logic                   hp_pend_r, hp_pend_nxt;

  // working registers
  logic [P-1:0]      mag_r;
  logic [PROD_W-1:0] prod_r;
  logic                         out_valid_r;
  logic [stm3_pkg::OUT_TDATA_W-1:0] out_data_r;

  // divider
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] quo;

  // operand and math signals
  logic [TGT_W:0]         tgt_sx;
  logic [TGT_W:0]         tgt_abs;
  logic [UPS_W-1:0]       ups_eff;
  logic [IDX_W-1:0]       idx_eff;
  logic [DVS_W-1:0]       idx3;
  logic [TGT_W:0]         q_lo;
  logic [TGT_W:0]         tq;
  logic signed [EXT_W-1:0] tq_ext;
  logic [P-1:0]           tstep;
  logic [P:0]             dl;
  logic [P:0]             mag_full;
  logic [DVD_W+BASE_W-1:0] mprod;
  logic [2*DVD_W-1:0]     mag3_prod;
  logic [PROD_W-1:0]      p_raw;
  logic [SAT_W-1:0]       p_w;
  logic [PERIOD_BITS-1:0] hp_sat;
  logic [PERIOD_BITS-1:0] hp;
  logic [IDX_W-1:0]       idx_inc;
  logic                   adv;
  stm3_pkg::phase_t       ph_adv;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ups_r  <= stm3_pkg::UPS_RESET;
      base_r <= stm3_pkg::BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stm3_pkg::REG_UPS:  ups_r  <= cfg_data[UPS_W-1:0];
        stm3_pkg::REG_BASE: base_r <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- request latch ----------------
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r <= in_tuser;
      tgt_r <= in_tdata[TGT_W-1:0];
      sws_r <= in_tdata[TGT_W];
      swe_r <= in_tdata[TGT_W+1];
    end
  end

  // ---------------- divider operands ----------------
  always_comb begin
    tgt_sx  = {tgt_r[TGT_W-1], tgt_r};
    tgt_abs = tgt_r[TGT_W-1] ? (~tgt_sx + 1'b1) : tgt_sx;
    ups_eff = (ups_r == '0) ? UPS_W'(1) : ups_r;
    idx_eff = (idx_r == '0) ? IDX_W'(1) : idx_r;
    idx3    = DVS_W'(idx_eff) + DVS_W'({idx_eff, 1'b0});
    case (cmd.div_sel)
      stm3_pkg::DIV_TGT: begin
        div_dvd = DVD_W'(tgt_abs);
        div_dvs = DVS_W'(ups_eff);
      end
      stm3_pkg::DIV_HP: begin
        div_dvd = DVD_W'(anum_r);
        div_dvs = idx3;
      end
      default: begin
        div_dvd = '0;
        div_dvs = DVS_W'(1);
      end
    endcase
  end

  stm3_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (quo)
  );

  // ---------------- move setup math ----------------
  always_comb begin
    // quotient truncates toward zero, so re-apply the sign afterwards
    q_lo      = quo[TGT_W:0];
    tq        = tgt_r[TGT_W-1] ? (~q_lo + 1'b1) : q_lo;
    tq_ext    = EXT_W'($signed(tq));
    tstep     = tq_ext[P-1:0];
    dl        = {tstep[P-1], tstep} - {pos_r[P-1], pos_r};
    mag_full  = dl[P] ? (~dl + 1'b1) : dl;
    mprod     = DVD_W'(mag_r) * base_r;
    mag3_prod = DVD_W'(mag_r) * stm3_pkg::THIRD_RECIP;
  end

  // ---------------- half-period math ----------------
  always_comb begin
    case (phase_r)
      stm3_pkg::PH_ACCEL:  p_raw = PROD_W'(quo);
      stm3_pkg::PH_CRUISE: p_raw = PROD_W'(base_r);
      stm3_pkg::PH_DECEL:  p_raw = prod_r;
      default:             p_raw = PROD_W'(1);
    endcase
    p_w    = SAT_W'(p_raw);
    hp_sat = (p_w > SAT_W'({PERIOD_BITS{1'b1}})) ? {PERIOD_BITS{1'b1}}
                                                 : p_w[PERIOD_BITS-1:0];
    hp     = (hp_sat == '0) ? PERIOD_BITS'(1) : hp_sat;
  end

  // ---------------- tick helpers ----------------
  always_comb begin
    idx_inc = idx_r + 1'b1;
    adv     = (idx_inc > IDX_W'(ppp_r));
    case (phase_r)
      stm3_pkg::PH_ACCEL:  ph_adv = stm3_pkg::PH_CRUISE;
      stm3_pkg::PH_CRUISE: ph_adv = stm3_pkg::PH_DECEL;
      default:             ph_adv = stm3_pkg::PH_IDLE;
    endcase
  end

  // ---------------- state update ----------------
  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    ppp_nxt     = ppp_r;
    anum_nxt    = anum_r;
    count_nxt   = count_r;
    level_nxt   = level_r;
    dir_nxt     = dir_r;
    abort_nxt   = abort_r;
    hp_pend_nxt = hp_pend_r;

    if (cmd.pos_update) begin
      pos_nxt = tstep;
      dir_nxt = !dl[P] && (dl != '0);
    end

    if (cmd.move_load) begin
      ppp_nxt   = mag3_prod[stm3_pkg::THIRD_SHIFT +: PPP_W] + 1'b1;
      anum_nxt  = mprod[ANUM_W-1:0];
      phase_nxt = stm3_pkg::PH_ACCEL;
      idx_nxt   = '0;
      count_nxt = '0;
      level_nxt = 1'b1;
      abort_nxt = 1'b0;
    end

    if (cmd.tick_apply) begin
      abort_nxt   = 1'b0;
      hp_pend_nxt = 1'b0;
      if (phase_r != stm3_pkg::PH_IDLE) begin
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end else if (!level_r) begin
          level_nxt   = 1'b1;
          hp_pend_nxt = 1'b1;
        end else if (adv && (phase_r == stm3_pkg::PH_DECEL)) begin
          phase_nxt = stm3_pkg::PH_IDLE;
          idx_nxt   = '0;
        end else if (!sws_r || !swe_r) begin
          // either end switch pressed at pulse start stops the move
          phase_nxt = stm3_pkg::PH_IDLE;
          idx_nxt   = '0;
          abort_nxt = 1'b1;
        end else begin
          level_nxt   = 1'b0;
          hp_pend_nxt = 1'b1;
          phase_nxt   = adv ? ph_adv : phase_r;
          idx_nxt     = adv ? IDX_W'(1) : idx_inc;
        end
      end
    end

    if (cmd.hp_load) begin
      count_nxt = hp - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= stm3_pkg::PH_IDLE;
      idx_r     <= '0;
      ppp_r     <= '0;
      anum_r    <= '0;
      count_r   <= '0;
      level_r   <= 1'b1;
      dir_r     <= 1'b0;
      abort_r   <= 1'b0;
      hp_pend_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      ppp_r     <= ppp_nxt;
      anum_r    <= anum_nxt;
      count_r   <= count_nxt;
      level_r   <= level_nxt;
      dir_r     <= dir_nxt;
      abort_r   <= abort_nxt;
      hp_pend_r <= hp_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_update) begin
      mag_r <= mag_full[P-1:0];
    end
    if (cmd.mul_load) begin
      prod_r <= PROD_W'(base_r) * PROD_W'(idx_eff);
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {4'b0000, abort_r, (phase_r != stm3_pkg::PH_IDLE), dir_r, level_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    st.action      = act_r;
    st.hp_pend     = hp_pend_r;
    st.phase_accel = (phase_r == stm3_pkg::PH_ACCEL);
    st.div_done    = div_done;
    st.out_free    = !out_valid_r || out_tready;
  end

  // ---------------- assertions ----------------
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while still pending");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == stm3_pkg::PH_IDLE) |-> (idx_r == '0))
    else $error("pulse index nonzero while no move runs");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != stm3_pkg::PH_IDLE) |-> (idx_r <= IDX_W'(ppp_r) + 1'b1))
    else $error("pulse index ran past the phase length");

  a_hp_load_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hp_load |-> (phase_r != stm3_pkg::PH_IDLE))
    else $error("half-period loaded with no move running");

endmodule

/* rtl/core/stepper_three_phase_move_top.sv */
// ----------------------------------------------------------------------------
// stepper_three_phase_move_top
// Step pulse generator for one stepper axis with accelerate, cruise and
// decelerate phases.
// ----------------------------------------------------------------------------
// Every request on the in_ stream gives exactly one result on the out_ stream.
// A request with in_tuser = 1 is a move to in_tdata's target position; one
// with in_tuser = 0 is one time tick, on which the step pin, direction, busy
// and abort flags are reported. Requests are handled one at a time by a
// sequencer and a single shared 1-bit-per-cycle divider: a tick passes
// through dispatch, the half-period check and the output state, adding a
// multiply step when it starts a cruise or decelerate half-period and a
// divide when it starts an accelerate half-period; a move takes one divide
// for the target, |d| / 3 by reciprocal multiply. A pending result that
// out_tready has not taken holds the next request in the output state. A new
// request is taken while the previous result still waits in the output register.
// Configuration writes (index 0: units_per_step, index 1: base_half_period)
// take effect at once and belong between requests.
// ----------------------------------------------------------------------------
module stepper_three_phase_move_top #(
  parameter int POSITION_BITS = 16,
  parameter int PERIOD_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [15:0] target_position, [16] start_switch_n, [17] end_switch_n
  input  logic [stm3_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: [0] action
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: [0] step_out, [1] direction, [2] busy_res, [3] aborted
  output logic [stm3_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [stm3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stm3_pkg::CFG_DATA_W-1:0]      cfg_data
);

  stm3_pkg::ctrl_cmd_t  cmd;
  stm3_pkg::ctrl_stat_t st;

  stm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  stm3_dp #(
    .POSITION_BITS (POSITION_BITS),
    .PERIOD_BITS   (PERIOD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* tb/sv/stepper_three_phase_move_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_three_phase_move_top_tb
// Self-checking bench for the three-phase stepper move generator. Moves and
// ticks are streamed in. Each request's pin levels are worked out by a local
// profile model and queued. Every result is checked against the oldest entry.
// Directed cases come first, then random move sequences under several
// configurations and stall patterns.
// ----------------------------------------------------------------------------
module stepper_three_phase_move_top_tb;

  localparam int POSITION_BITS = 16;
  localparam int PERIOD_BITS   = 32;
  localparam int SEG_ITEMS     = 43;

  typedef struct packed {
    logic step;
    logic dir;
    logic busy;
    logic aborted;
  } pin_state_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [stm3_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [stm3_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [stm3_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [stm3_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  stepper_three_phase_move_top #(
    .POSITION_BITS(POSITION_BITS),
    .PERIOD_BITS  (PERIOD_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register shadows
  logic [stm3_pkg::UPS_W-1:0]  ups_shadow  = stm3_pkg::UPS_RESET;
  logic [stm3_pkg::BASE_W-1:0] base_shadow = stm3_pkg::BASE_RESET;

  // axis profile state
  logic signed [POSITION_BITS-1:0] axis_pos = '0;
  stm3_pkg::phase_t axis_phase = stm3_pkg::PH_IDLE;
  int      pulse_idx = 0;
  int      pulses_per_phase = 0;
  longint  accel_num = 0;
  longint  half_cnt = 0;
  logic    step_lvl = 1'b1;
  logic    dir_lvl = 1'b0;

  pin_state_t pin_levels_q[$];
  int err_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL stepper_three_phase_move_top");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_error(input string msg);
    if (err_count < 30) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint profile_half_period();
    longint p;
    longint i;
    i = (pulse_idx == 0) ? 1 : pulse_idx;
    case (axis_phase)
      stm3_pkg::PH_ACCEL:  p = accel_num / (3 * i);
      stm3_pkg::PH_CRUISE: p = base_shadow;
      default:             p = longint'(base_shadow) * i;
    endcase
    if (p > ((64'd1 << PERIOD_BITS) - 1)) p = (64'd1 << PERIOD_BITS) - 1;
    if (p < 1) p = 1;
    return p;
  endfunction

  // advances the axis model by one request and returns its pin levels
  function automatic pin_state_t predict_pins(input logic move, input logic signed [15:0] tgt,
                                              input logic start_sw_n, input logic end_sw_n);
    pin_state_t r;
    int divisor;
    int delta;
    int mag;
    logic signed [POSITION_BITS-1:0] new_pos;
    logic hit;
    logic done;
    hit = 1'b0;
    done = 1'b0;
    if (move) begin
      divisor = (ups_shadow == 0) ? 1 : int'(ups_shadow);
      new_pos = POSITION_BITS'(int'(tgt) / divisor);
      delta = int'(new_pos) - int'(axis_pos);
      dir_lvl = (delta > 0);
      mag = (delta < 0) ? -delta : delta;
      axis_pos = new_pos;
      pulses_per_phase = (1 + mag / 3) & 16'hFFFF;
      accel_num = (longint'(base_shadow) * mag) & 64'hFFFF_FFFF;
      axis_phase = stm3_pkg::PH_ACCEL;
      pulse_idx = 0;
      half_cnt = 0;
      step_lvl = 1'b1;
    end else if (axis_phase != stm3_pkg::PH_IDLE) begin
      if (half_cnt > 0) begin
        half_cnt--;
      end else if (!step_lvl) begin
        step_lvl = 1'b1;
        half_cnt = profile_half_period() - 1;
      end else begin
        pulse_idx++;
        if (pulse_idx > pulses_per_phase) begin
          pulse_idx = 1;
          case (axis_phase)
            stm3_pkg::PH_ACCEL:  axis_phase = stm3_pkg::PH_CRUISE;
            stm3_pkg::PH_CRUISE: axis_phase = stm3_pkg::PH_DECEL;
            default:             done = 1'b1;
          endcase
        end
        if (done) begin
          axis_phase = stm3_pkg::PH_IDLE;
          pulse_idx = 0;
        end else if (!start_sw_n || !end_sw_n) begin
          // switches are only looked at when a pulse would start
          axis_phase = stm3_pkg::PH_IDLE;
          pulse_idx = 0;
          hit = 1'b1;
        end else begin
          step_lvl = 1'b0;
          half_cnt = profile_half_period() - 1;
        end
      end
    end
    r.step = step_lvl;
    r.dir = dir_lvl;
    r.busy = (axis_phase != stm3_pkg::PH_IDLE);
    r.aborted = hit;
    return r;
  endfunction

  // one request; entered and left on a rising edge
  task automatic send_item(input logic move, input logic signed [15:0] tgt,
                           input logic start_sw_n, input logic end_sw_n);
    logic took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= move;
    in_tdata <= {{(stm3_pkg::IN_TDATA_W-18){1'b0}}, end_sw_n, start_sw_n, tgt};
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    pin_levels_q.push_back(predict_pins(move, tgt, start_sw_n, end_sw_n));
    items_sent++;
  endtask

  task automatic send_tick(input logic start_sw_n, input logic end_sw_n);
    send_item(1'b0, 16'($urandom), start_sw_n, end_sw_n);
  endtask

  // hold off until the block has returned everything, then let it settle
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [stm3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [stm3_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == stm3_pkg::REG_UPS) ups_shadow = value[stm3_pkg::UPS_W-1:0];
    else base_shadow = value[stm3_pkg::BASE_W-1:0];
  endtask

  task automatic set_profile(input int ups, input int base);
    drain_block();
    cfg_write(stm3_pkg::REG_UPS, stm3_pkg::CFG_DATA_W'(ups));
    cfg_write(stm3_pkg::REG_BASE, stm3_pkg::CFG_DATA_W'(base));
  endtask

  // ticks until the model says the move is over, or cap ticks
  task automatic run_out_move(input int cap);
    int n;
    n = 0;
    while (axis_phase != stm3_pkg::PH_IDLE && n < cap) begin
      if ($urandom_range(0, 99) < 3) begin
        if ($urandom_range(0, 1)) send_tick(1'b0, 1'($urandom));
        else send_tick(1'b1, 1'b0);
      end else begin
        send_tick(1'b1, 1'b1);
      end
      n++;
    end
  endtask

  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
  endtask

  task automatic test_zero_distance();
    set_profile(1, 1);
    send_item(1'b1, 16'sd0, 1'b1, 1'b1);
    run_out_move(20);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_command_while_busy();
    send_item(1'b1, 16'sd32767, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_item(1'b1, -16'sd32768, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_switch_abort();
    send_item(1'b1, 16'sd100, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_item(1'b1, 16'sd50, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_zero_config();
    set_profile(0, 0);
    send_item(1'b1, 16'sd51, 1'b1, 1'b1);
    run_out_move(20);
  endtask

  task automatic test_extreme_config();
    set_profile(255, 65535);
    send_item(1'b1, -16'sd32768, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_item(1'b1, 16'sd32767, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic random_segment(input int n_items);
    int stop_at;
    int sel;
    int divisor;
    int tgt;
    int cap;
    int left;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      divisor = (ups_shadow == 0) ? 1 : int'(ups_shadow);
      cap = (base_shadow > 16) ? $urandom_range(1, 20) : 200;
      if (sel < 75) begin
        // short move near the current position, mostly run to the end
        tgt = (int'(axis_pos) + $urandom_range(0, 20) - 10) * divisor;
        if (tgt > 32767 || tgt < -32768) tgt = int'($signed(16'($urandom)));
        send_item(1'b1, 16'(tgt), 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 9) == 0) cap = $urandom_range(0, 6);
        left = stop_at - items_sent;
        run_out_move((cap < left) ? cap : left);
      end else if (sel < 87) begin
        send_item(1'b1, 16'($urandom), 1'($urandom), 1'($urandom));
        cap = $urandom_range(1, 15);
        left = stop_at - items_sent;
        run_out_move((cap < left) ? cap : left);
      end else begin
        cap = $urandom_range(1, 5);
        left = stop_at - items_sent;
        repeat ((cap < left) ? cap : left) send_tick(1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_random_moves();
    int send_tab[4] = '{0, 54, 0, 6};
    int recv_tab[4] = '{0, 0, 54, 6};
    int ups_tab[6]  = '{1, 255, 0, 7, 1, 255};
    int base_tab[6] = '{1, 3, 0, 2, 65535, 65535};
    for (int s = 0; s < 12; s++) begin
      set_profile(ups_tab[s % 6], base_tab[s % 6]);
      send_idle_pct = send_tab[s / 3];
      recv_stall_pct = recv_tab[s / 3];
      random_segment(SEG_ITEMS);
    end
  endtask

  always @(negedge clk) begin : check_results
    pin_state_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pin_levels_q.size() == 0) begin
        report_error($sformatf("result %0d with nothing outstanding", results_seen));
      end else begin
        want = pin_levels_q.pop_front();
        if (out_tdata[0] !== want.step)
          report_error($sformatf("result %0d step_out %b want %b", results_seen,
                                 out_tdata[0], want.step));
        if (out_tdata[1] !== want.dir)
          report_error($sformatf("result %0d direction %b want %b", results_seen,
                                 out_tdata[1], want.dir));
        if (out_tdata[2] !== want.busy)
          report_error($sformatf("result %0d busy %b want %b", results_seen,
                                 out_tdata[2], want.busy));
        if (out_tdata[3] !== want.aborted)
          report_error($sformatf("result %0d aborted %b want %b", results_seen,
                                 out_tdata[3], want.aborted));
      end
      results_seen++;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_zero_distance();
    test_command_while_busy();
    test_switch_abort();
    test_zero_config();
    test_extreme_config();
    test_random_moves();
    drain_block();
    if (err_count == 0 && pin_levels_q.size() == 0) begin
      $display("PASS stepper_three_phase_move_top");
    end else begin
      $display("FAIL stepper_three_phase_move_top");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/stm3_pkg.sv
rtl/core/stm3_div.sv
rtl/core/stm3_ctrl.sv
rtl/core/stm3_dp.sv
rtl/core/stepper_three_phase_move_top.sv
tb/sv/stepper_three_phase_move_top_tb.sv
